@@ src/bchq_pkg.sv @@
// Package for the button click / hold qualifier.
// Holds shared types, configuration register indexes and reset values.
// No dependencies.
package bchq_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned EvW   = 4;
  localparam int unsigned CfgIdxW = 3;

  // Reset values of the configuration registers, in milliseconds.
  localparam logic [CfgW-1:0] DebounceRst   = 16'd50;
  localparam logic [CfgW-1:0] LongPressRst  = 16'd1000;
  localparam logic [CfgW-1:0] VeryLongRst   = 16'd3000;
  localparam logic [CfgW-1:0] CooldownRst   = 16'd200;
  localparam logic [CfgW-1:0] IgnoreRst     = 16'd300;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEBOUNCE  = 3'd0,
    CFG_LONG      = 3'd1,
    CFG_VERY_LONG = 3'd2,
    CFG_COOLDOWN  = 3'd3,
    CFG_IGNORE    = 3'd4
  } cfg_idx_e;

  // One poll as held in the input register.
  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic [EvW-1:0]   key_events;
    logic             b_level;
  } poll_t;

  // Pulses of button B for one poll.
  typedef struct packed {
    logic click;
    logic hold;
    logic very_long;
  } b_pulse_t;

  // One result beat.
  typedef struct packed {
    logic     a_click;
    b_pulse_t b;
  } result_t;

endpackage

@@ src/button_click_hold_qualifier_top.sv @@
// Top level of the button click / hold qualifier.
// Each poll passes the input register and then the result register.
// Throughput: one poll per cycle; the input register and the result register
// each advance whenever the stage after them is empty or not stalled.
// Reset: asynchronous, active low; clears all qualifier state and loads the
// default timing registers. Depends on bchq_pkg, bchq_a_click, bchq_b_button.
module button_click_hold_qualifier_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Poll input channel.
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [bchq_pkg::TimeW-1:0]         now_ms_i,
  input  logic [bchq_pkg::EvW-1:0]           key_events_i,
  input  logic                               b_level_pressed_i,
  // Result channel.
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               a_click_o,
  output logic                               b_click_o,
  output logic                               b_hold_o,
  output logic                               b_very_long_o,
  // Configuration write port.
  input  logic                               cfg_we_i,
  input  logic [bchq_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [bchq_pkg::CfgW-1:0]          cfg_data_i
);

  // Timing registers, all in milliseconds.
  logic [bchq_pkg::CfgW-1:0] debounce_q;
  logic [bchq_pkg::CfgW-1:0] long_q;
  logic [bchq_pkg::CfgW-1:0] very_long_q;
  logic [bchq_pkg::CfgW-1:0] cooldown_q;
  logic [bchq_pkg::CfgW-1:0] ignore_q;

  // Input register holding the poll under evaluation.
  logic                in_vld_q, in_vld_d;
  bchq_pkg::poll_t     in_q;
  // Result register.
  logic                out_vld_q, out_vld_d;
  bchq_pkg::result_t   out_q;
  bchq_pkg::result_t   result;

  logic advance;   // result register can take a new beat this cycle
  logic step;      // the held poll is evaluated and the qualifier state moves
  logic accept;    // a new poll beat enters the input register

  // The result register frees up when it is empty or its beat is taken.
  assign advance    = ~out_vld_q | ~out_stall_i;
  assign step       = in_vld_q & advance;
  // The input register refills in the same cycle it hands its poll onward,
  // so polls stream at full rate while the output side keeps up.
  assign in_stall_o = in_vld_q & ~advance;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (step) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = in_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers carry no reset; their valid flags guard them.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q.now_ms     <= now_ms_i;
      in_q.key_events <= key_events_i;
      in_q.b_level    <= b_level_pressed_i;
    end
    if (step) begin
      out_q <= result;
    end
  end

  // Configuration writes. Indexes past the last register are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q  <= bchq_pkg::DebounceRst;
      long_q      <= bchq_pkg::LongPressRst;
      very_long_q <= bchq_pkg::VeryLongRst;
      cooldown_q  <= bchq_pkg::CooldownRst;
      ignore_q    <= bchq_pkg::IgnoreRst;
    end else if (cfg_we_i) begin
      case (bchq_pkg::cfg_idx_e'(cfg_idx_i))
        bchq_pkg::CFG_DEBOUNCE:  debounce_q  <= cfg_data_i;
        bchq_pkg::CFG_LONG:      long_q      <= cfg_data_i;
        bchq_pkg::CFG_VERY_LONG: very_long_q <= cfg_data_i;
        bchq_pkg::CFG_COOLDOWN:  cooldown_q  <= cfg_data_i;
        bchq_pkg::CFG_IGNORE:    ignore_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Button A: the release event qualified by the startup window and cooldown.
  bchq_a_click u_a_click (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .now_ms_i      (in_q.now_ms),
    .key_events_i  (in_q.key_events),
    .cooldown_i    (cooldown_q),
    .ignore_time_i (ignore_q),
    .a_click_o     (result.a_click)
  );

  // Button B: debounced level with hold, very-long and click pulses.
  bchq_b_button u_b_button (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .now_ms_i    (in_q.now_ms),
    .b_level_i   (in_q.b_level),
    .debounce_i  (debounce_q),
    .long_i      (long_q),
    .very_long_i (very_long_q),
    .pulse_o     (result.b)
  );

  assign out_valid_o   = out_vld_q;
  assign a_click_o     = out_q.a_click;
  assign b_click_o     = out_q.b.click;
  assign b_hold_o      = out_q.b.hold;
  assign b_very_long_o = out_q.b.very_long;

endmodule

@@ src/bchq_a_click.sv @@
// Button A qualifier: first-poll flush, startup ignore window and click cooldown.
// Depends on bchq_pkg.
module bchq_a_click (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [bchq_pkg::TimeW-1:0]  now_ms_i,
  input  logic [bchq_pkg::EvW-1:0]    key_events_i,
  input  logic [bchq_pkg::CfgW-1:0]   cooldown_i,
  input  logic [bchq_pkg::CfgW-1:0]   ignore_time_i,
  output logic                        a_click_o
);

  logic                       first_done_q, first_done_d;
  logic [bchq_pkg::TimeW-1:0] ignore_until_q, ignore_until_d;
  logic [bchq_pkg::TimeW-1:0] last_click_q, last_click_d;
  logic                       release_ev;
  logic                       raw_a;
  logic [bchq_pkg::TimeW-1:0] since_click;

  always_comb begin
    first_done_d   = first_done_q;
    ignore_until_d = ignore_until_q;
    last_click_d   = last_click_q;
    // Events pending at the first poll are boot leftovers and are dropped.
    release_ev  = first_done_q & key_events_i[0];
    raw_a       = release_ev & ~(now_ms_i < ignore_until_q);
    since_click = now_ms_i - last_click_q;
    a_click_o   = raw_a &
                  (since_click >= {{(bchq_pkg::TimeW-bchq_pkg::CfgW){1'b0}}, cooldown_i});
    if (!first_done_q) begin
      first_done_d = 1'b1;
      if (key_events_i != '0) begin
        ignore_until_d = now_ms_i +
                         {{(bchq_pkg::TimeW-bchq_pkg::CfgW){1'b0}}, ignore_time_i};
      end
    end
    if (a_click_o) begin
      last_click_d = now_ms_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_done_q   <= 1'b0;
      ignore_until_q <= '0;
      last_click_q   <= '0;
    end else if (step_i) begin
      first_done_q   <= first_done_d;
      ignore_until_q <= ignore_until_d;
      last_click_q   <= last_click_d;
    end
  end

endmodule

@@ src/bchq_b_button.sv @@
// Button B qualifier: debounce, one-shot hold and very-long pulses, click if released before hold.
// Depends on bchq_pkg.
module bchq_b_button (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [bchq_pkg::TimeW-1:0]  now_ms_i,
  input  logic                        b_level_i,
  input  logic [bchq_pkg::CfgW-1:0]   debounce_i,
  input  logic [bchq_pkg::CfgW-1:0]   long_i,
  input  logic [bchq_pkg::CfgW-1:0]   very_long_i,
  output bchq_pkg::b_pulse_t          pulse_o
);

  localparam int unsigned PadW = bchq_pkg::TimeW - bchq_pkg::CfgW;

  logic                       level_q, level_d;
  logic [bchq_pkg::TimeW-1:0] last_change_q, last_change_d;
  logic [bchq_pkg::TimeW-1:0] press_start_q, press_start_d;
  logic                       hold_fired_q, hold_fired_d;
  logic                       vl_fired_q, vl_fired_d;
  logic [bchq_pkg::TimeW-1:0] since_change;
  logic [bchq_pkg::TimeW-1:0] held;
  logic                       stable;

  always_comb begin
    level_d       = level_q;
    last_change_d = last_change_q;
    press_start_d = press_start_q;
    hold_fired_d  = hold_fired_q;
    vl_fired_d    = vl_fired_q;
    pulse_o       = '0;
    since_change  = now_ms_i - last_change_q;
    held          = now_ms_i - press_start_q;
    stable        = level_q;

    if ((b_level_i != level_q) && (since_change >= {{PadW{1'b0}}, debounce_i})) begin
      stable        = b_level_i;
      last_change_d = now_ms_i;
    end

    if (stable && !level_q) begin
      press_start_d = now_ms_i;
      hold_fired_d  = 1'b0;
      vl_fired_d    = 1'b0;
    end else if (stable && level_q) begin
      if (!hold_fired_q && (held >= {{PadW{1'b0}}, long_i})) begin
        pulse_o.hold = 1'b1;
        hold_fired_d = 1'b1;
      end
      if (!vl_fired_q && (held >= {{PadW{1'b0}}, very_long_i})) begin
        pulse_o.very_long = 1'b1;
        vl_fired_d        = 1'b1;
      end
    end else if (!stable && level_q) begin
      pulse_o.click = ~hold_fired_q;
      press_start_d = '0;
      hold_fired_d  = 1'b0;
      vl_fired_d    = 1'b0;
    end
    level_d = stable;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q       <= 1'b0;
      last_change_q <= '0;
      press_start_q <= '0;
      hold_fired_q  <= 1'b0;
      vl_fired_q    <= 1'b0;
    end else if (step_i) begin
      level_q       <= level_d;
      last_change_q <= last_change_d;
      press_start_q <= press_start_d;
      hold_fired_q  <= hold_fired_d;
      vl_fired_q    <= vl_fired_d;
    end
  end

endmodule

@@ tb/tb_button_click_hold_qualifier_top.sv @@
// Self-checking testbench for button_click_hold_qualifier_top: directed polls,
// timing-register extremes, receiver back-pressure and random poll streams.
// Depends on bchq_pkg and the qualifier RTL only.
module tb_button_click_hold_qualifier_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Field and register widths, taken from the package.
  localparam int unsigned TimeW   = bchq_pkg::TimeW;
  localparam int unsigned EvW     = bchq_pkg::EvW;
  localparam int unsigned CfgW    = bchq_pkg::CfgW;
  localparam int unsigned CfgIdxW = bchq_pkg::CfgIdxW;

  // Number of timing registers; indexes at or above this are not decoded.
  localparam int unsigned NumCfgRegs    = 5;
  // Length of the one long receiver hold-off, in cycles.
  localparam int unsigned HoldOffCycles = 80;
  // Cycles without any accepted beat or register write before giving up.
  localparam int unsigned WatchdogLimit = 2000;
  // Cycles allowed after the last result beat; the block has two stages.
  localparam int unsigned DrainCycles   = 4;
  // Random polls per random phase.
  localparam int unsigned PhaseItems    = 220;

  // Clock, reset and every block input start at a known value.
  logic               clk_i             = 1'b0;
  logic               rst_ni            = 1'b0;
  logic               in_valid_i        = 1'b0;
  logic               in_stall_o;
  logic [TimeW-1:0]   now_ms_i          = '0;
  logic [EvW-1:0]     key_events_i      = '0;
  logic               b_level_pressed_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i       = 1'b0;
  logic               a_click_o;
  logic               b_click_o;
  logic               b_hold_o;
  logic               b_very_long_o;
  logic               cfg_we_i          = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i         = '0;
  logic [CfgW-1:0]    cfg_data_i        = '0;

  button_click_hold_qualifier_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .now_ms_i          (now_ms_i),
    .key_events_i      (key_events_i),
    .b_level_pressed_i (b_level_pressed_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .a_click_o         (a_click_o),
    .b_click_o         (b_click_o),
    .b_hold_o          (b_hold_o),
    .b_very_long_o     (b_very_long_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Our own copy of the timing registers, loaded with the reset values.
  logic [CfgW-1:0] timing_ms [NumCfgRegs] =
    '{bchq_pkg::DebounceRst, bchq_pkg::LongPressRst, bchq_pkg::VeryLongRst,
      bchq_pkg::CooldownRst, bchq_pkg::IgnoreRst};

  // Qualifier state as we expect it to be after every accepted poll.
  logic             poll_seen        = 1'b0;
  logic [TimeW-1:0] a_window_end     = '0;
  logic [TimeW-1:0] a_last_click_ms  = '0;
  logic [TimeW-1:0] b_last_change_ms = '0;
  logic             b_debounced      = 1'b0;
  logic [TimeW-1:0] b_press_ms       = '0;
  logic             b_hold_sent      = 1'b0;
  logic             b_very_long_sent = 1'b0;

  // Pulses expected for polls that went in but whose result beat is still due.
  bchq_pkg::result_t pending_pulses [$];
  int                pulse_errors = 0;

  // Handshake pacing. The sender and the receiver each draw a random wait per
  // beat while their flag is set; the test tasks turn the flags off for
  // stretches of back-to-back traffic.
  bit idle_on      = 1'b1;
  bit stall_on     = 1'b1;
  bit hold_off_req = 1'b0;

  // Poll time and the intended level of button B for the random stream.
  logic [TimeW-1:0] clock_ms   = '0;
  bit               b_intent   = 1'b0;
  int unsigned      b_run_left = 0;

  // Works out the pulses of one poll and advances the expected state.
  function automatic bchq_pkg::result_t qualify_poll(input logic [TimeW-1:0] now,
                                                     input logic [EvW-1:0]   events,
                                                     input logic             raw_b);
    bchq_pkg::result_t pulses;
    logic [EvW-1:0]    ev;
    logic              level;
    logic [TimeW-1:0]  held;
    pulses = '0;
    ev     = events;
    // The first poll flushes whatever events piled up before it. The ignore
    // window only opens if something was actually pending.
    if (!poll_seen) begin
      poll_seen = 1'b1;
      if (ev != '0) begin
        a_window_end = now + TimeW'(timing_ms[bchq_pkg::CFG_IGNORE]);
      end
      ev = '0;
    end
    // A release counts outside the window (a plain unsigned compare, so a
    // window end that wrapped past zero is already over) and after cooldown.
    if (ev[0] && !(now < a_window_end) &&
        (now - a_last_click_ms) >= TimeW'(timing_ms[bchq_pkg::CFG_COOLDOWN])) begin
      pulses.a_click  = 1'b1;
      a_last_click_ms = now;
    end
    // Debounce: a change of B only sticks once enough time has passed since
    // the previous accepted change.
    level = b_debounced;
    if (raw_b != b_debounced &&
        (now - b_last_change_ms) >= TimeW'(timing_ms[bchq_pkg::CFG_DEBOUNCE])) begin
      level            = raw_b;
      b_last_change_ms = now;
    end
    if (level && !b_debounced) begin
      b_press_ms       = now;
      b_hold_sent      = 1'b0;
      b_very_long_sent = 1'b0;
    end else if (level && b_debounced) begin
      // Hold and very-long are independent, so one poll can raise both.
      held = now - b_press_ms;
      if (!b_hold_sent && held >= TimeW'(timing_ms[bchq_pkg::CFG_LONG])) begin
        pulses.b.hold = 1'b1;
        b_hold_sent   = 1'b1;
      end
      if (!b_very_long_sent &&
          held >= TimeW'(timing_ms[bchq_pkg::CFG_VERY_LONG])) begin
        pulses.b.very_long = 1'b1;
        b_very_long_sent   = 1'b1;
      end
    end else if (!level && b_debounced) begin
      // A release only clicks if the press never got as far as a hold.
      if (!b_hold_sent) begin
        pulses.b.click = 1'b1;
      end
      b_press_ms       = '0;
      b_hold_sent      = 1'b0;
      b_very_long_sent = 1'b0;
    end
    b_debounced = level;
    return pulses;
  endfunction

  // Offers one poll after a random gap and holds it until the block takes it.
  // Valid is only lowered when a gap is drawn, so back-to-back beats keep it
  // high without a second assignment in the same time step.
  task automatic send_poll(input logic [TimeW-1:0] now,
                           input logic [EvW-1:0]   events,
                           input logic             raw_b);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i        <= 1'b1;
    now_ms_i          <= now;
    key_events_i      <= events;
    b_level_pressed_i <= raw_b;
    do @(posedge clk_i); while (in_stall_o);
    pending_pulses.push_back(qualify_poll(now, events, raw_b));
  endtask

  // Register writes happen only while the block is idle, so the expected
  // copy can be updated on the spot. Undecoded indexes change nothing.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx,
                           input logic [CfgW-1:0]    data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx < NumCfgRegs) begin
      timing_ms[idx] = data;
    end
  endtask

  task automatic set_timing(input logic [CfgW-1:0] debounce,
                            input logic [CfgW-1:0] long_press,
                            input logic [CfgW-1:0] very_long,
                            input logic [CfgW-1:0] cooldown,
                            input logic [CfgW-1:0] ignore);
    write_reg(bchq_pkg::CFG_DEBOUNCE, debounce);
    write_reg(bchq_pkg::CFG_LONG, long_press);
    write_reg(bchq_pkg::CFG_VERY_LONG, very_long);
    write_reg(bchq_pkg::CFG_COOLDOWN, cooldown);
    write_reg(bchq_pkg::CFG_IGNORE, ignore);
  endtask

  // Drops valid and waits until every poll in flight has produced its beat.
  task automatic settle_block();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_pulses.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // One poll of the random stream. Time mostly creeps forward by up to
  // step_max ms, with rare jumps anywhere in the 32-bit range. Button B
  // follows runs of one intended level with occasional bounce on top, so
  // debounced presses last long enough to reach hold and very-long.
  task automatic random_poll(input int unsigned step_max);
    logic [EvW-1:0] ev;
    logic           raw_b;
    if ($urandom_range(0, 99) < 2) begin
      clock_ms = $urandom();
    end else begin
      clock_ms = clock_ms + $urandom_range(0, step_max);
    end
    if (b_run_left == 0) begin
      b_intent   = !b_intent;
      b_run_left = $urandom_range(1, 40);
    end
    b_run_left--;
    raw_b  = b_intent ^ ($urandom_range(0, 7) == 0);
    ev[0]  = ($urandom_range(0, 3) == 0);
    ev[EvW-1:1] = ($urandom_range(0, 3) == 0) ? (EvW-1)'($urandom_range(0, 7)) : '0;
    send_poll(clock_ms, ev, raw_b);
  endtask

  // The very first poll carries every event bit and a time close to the top
  // of the counter. The ignore window end therefore wraps to a small value:
  // a release just before the wrap already counts, one just after it is
  // ignored until the wrapped end is reached.
  task automatic test_first_poll_window();
    send_poll(32'hFFFF_FFF0, 4'hF, 1'b0);
    send_poll(32'hFFFF_FFF8, 4'h1, 1'b0);
    send_poll(32'h0000_0010, 4'h1, 1'b0);
    send_poll(32'h0000_0120, 4'h1, 1'b0);
  endtask

  // Other key events do nothing; a release clicks exactly at the cooldown
  // boundary and not one millisecond before it.
  task automatic test_a_cooldown();
    send_poll(32'h0000_0120 + 32'd199, 4'hE, 1'b0);
    send_poll(32'h0000_0120 + 32'd199, 4'h1, 1'b0);
    send_poll(32'h0000_0120 + 32'd200, 4'h1, 1'b0);
    send_poll(32'h0000_0120 + 32'd250, 4'hF, 1'b0);
  endtask

  // Button B at the default timing: bounce inside the debounce time, a short
  // press that clicks, a long press with hold and then very-long at their
  // exact thresholds, and a press whose first held poll fires both at once.
  task automatic test_b_debounce_hold();
    logic [TimeW-1:0] t;
    t = 32'h0000_1000;
    send_poll(t, '0, 1'b1);
    send_poll(t + 32'd10, '0, 1'b0);
    send_poll(t + 32'd60, '0, 1'b0);
    send_poll(t + 32'd70, '0, 1'b1);
    send_poll(t + 32'd110, '0, 1'b1);
    send_poll(t + 32'd1109, '0, 1'b1);
    send_poll(t + 32'd1110, '0, 1'b1);
    send_poll(t + 32'd3109, '0, 1'b1);
    send_poll(t + 32'd3110, '0, 1'b1);
    send_poll(t + 32'd3210, '0, 1'b0);
    send_poll(t + 32'd5000, '0, 1'b1);
    send_poll(t + 32'd9000, '0, 1'b1);
    send_poll(t + 32'd9100, '0, 1'b0);
  endtask

  // All registers at zero, then all at full scale, with writes to the
  // undecoded indexes in between that must leave full scale in place.
  task automatic test_config_extremes();
    logic [TimeW-1:0] t;
    t = 32'h0010_0000;
    settle_block();
    set_timing('0, '0, '0, '0, '0);
    // With zero times every poll may click A, and a press is held "long"
    // on its very next poll even at the same timestamp.
    send_poll(t, 4'h1, 1'b1);
    send_poll(t, 4'h1, 1'b1);
    send_poll(t, '0, 1'b0);
    send_poll(t, '0, 1'b1);
    send_poll(t, '0, 1'b0);
    settle_block();
    set_timing('1, '1, '1, '1, '1);
    for (int unsigned k = NumCfgRegs; k < (1 << CfgIdxW); k++) begin
      write_reg(CfgIdxW'(k), '0);
    end
    send_poll(t + 32'd1, 4'h1, 1'b1);
    send_poll(t + 32'd65535, 4'h1, 1'b1);
    send_poll(t + 32'd131070, '0, 1'b1);
    clock_ms = t + 32'd131070;
  endtask

  // The receiver stops for a long stretch while the sender keeps offering
  // polls back to back, so both stages fill and the input stalls.
  task automatic test_backpressure();
    settle_block();
    set_timing(bchq_pkg::DebounceRst, bchq_pkg::LongPressRst, bchq_pkg::VeryLongRst,
               bchq_pkg::CooldownRst, bchq_pkg::IgnoreRst);
    idle_on      = 1'b0;
    hold_off_req = 1'b1;
    repeat (30) random_poll(120);
  endtask

  task automatic run_random_phase(input int unsigned step_max);
    for (int unsigned i = 0; i < PhaseItems; i++) begin
      // Re-draw the pacing now and then; about a quarter of the stretches
      // on each side run without any idling.
      if (i % 60 == 0) begin
        idle_on  = ($urandom_range(0, 3) != 0);
        stall_on = ($urandom_range(0, 3) != 0);
      end
      random_poll(step_max);
    end
  endtask

  // Random streams under several timing settings: defaults, all zero, full
  // scale, and two random sets. The time step scales with the settings so
  // that holds and very-long presses still happen.
  task automatic test_random_phases();
    settle_block();
    set_timing(bchq_pkg::DebounceRst, bchq_pkg::LongPressRst, bchq_pkg::VeryLongRst,
               bchq_pkg::CooldownRst, bchq_pkg::IgnoreRst);
    run_random_phase(120);
    settle_block();
    set_timing('0, '0, '0, '0, '0);
    run_random_phase(8);
    settle_block();
    set_timing('1, '1, '1, '1, '1);
    run_random_phase(6000);
    settle_block();
    set_timing(CfgW'($urandom_range(0, 200)), CfgW'($urandom_range(0, 2000)),
               CfgW'($urandom_range(0, 4000)), CfgW'($urandom_range(0, 400)),
               CfgW'($urandom_range(0, 65535)));
    run_random_phase(150);
    settle_block();
    set_timing(CfgW'($urandom_range(0, 65535)), CfgW'($urandom_range(0, 65535)),
               CfgW'($urandom_range(0, 65535)), CfgW'($urandom_range(0, 65535)),
               CfgW'($urandom_range(0, 65535)));
    run_random_phase(3000);
  endtask

  // Receiver: before each beat it stalls for a random number of cycles, plus
  // the long hold-off once when a test asks for it. Stall changes only at
  // falling edges and at most once per edge.
  initial begin : result_sink
    int unsigned hold_cycles;
    forever begin
      @(negedge clk_i);
      hold_cycles = stall_on ? $urandom_range(0, 6) : 0;
      if (hold_off_req) begin
        hold_cycles += HoldOffCycles;
        hold_off_req = 1'b0;
      end
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_cycles) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  // Every accepted result beat is matched against the oldest expectation.
  always @(posedge clk_i) begin : result_check
    bchq_pkg::result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_pulses.size() == 0) begin
        $error("result beat with no poll pending");
        pulse_errors++;
      end else begin
        want = pending_pulses.pop_front();
        if (a_click_o !== want.a_click) begin
          $error("a_click: expected %0b, got %0b", want.a_click, a_click_o);
          pulse_errors++;
        end
        if (b_click_o !== want.b.click) begin
          $error("b_click: expected %0b, got %0b", want.b.click, b_click_o);
          pulse_errors++;
        end
        if (b_hold_o !== want.b.hold) begin
          $error("b_hold: expected %0b, got %0b", want.b.hold, b_hold_o);
          pulse_errors++;
        end
        if (b_very_long_o !== want.b.very_long) begin
          $error("b_very_long: expected %0b, got %0b", want.b.very_long, b_very_long_o);
          pulse_errors++;
        end
      end
    end
  end

  // Watchdog: any accepted beat or register write counts as progress.
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WatchdogLimit) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : main_sequence
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_first_poll_window();
    test_a_cooldown();
    test_b_debounce_hold();
    test_config_extremes();
    test_backpressure();
    test_random_phases();
    settle_block();
    if (pending_pulses.size() != 0) begin
      $error("%0d result beats never arrived", pending_pulses.size());
      pulse_errors++;
    end
    if (pulse_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/bchq_pkg.sv
src/bchq_a_click.sv
src/bchq_b_button.sv
src/button_click_hold_qualifier_top.sv
tb/tb_button_click_hold_qualifier_top.sv
